FILE: rtl/tmf_pkg.sv
// shared constants and types for the trimmed mean filter
package tmf_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 255;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int SAMPLE_W            = 16;
   localparam int MEAN_W              = 20;
   // samples dropped from each set: the largest and the smallest
   localparam int TRIM_COUNT          = 2;
   localparam int QUEUE_DEPTH         = 2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [MEAN_W-1:0]   mean_type;

endpackage

FILE: rtl/tmf_req_if.sv
// input and result channel interfaces of the trimmed mean filter
interface tmf_req_if import tmf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface tmf_rsp_if import tmf_pkg::*; ();
   logic     valid;
   logic     ready;
   mean_type mean_times_ten;
   logic     too_few;

   modport source (output valid, output mean_times_ten, output too_few, input ready);
   modport sink (input valid, input mean_times_ten, input too_few, output ready);
endinterface

FILE: rtl/tmf_front.sv
// front end: accumulates sum, extremes and count of a set, hands closed sets on
module tmf_front import tmf_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int COUNT_BITS = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS,
   localparam int JOB_BITS   = SUM_BITS + 2 * SAMPLE_BITS + COUNT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   tmf_req_if.sink             req_if,
   output logic                job_valid,
   output logic [JOB_BITS-1:0] job_data,
   input  logic                job_ready
);

   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SAMPLE_BITS-1:0] smp;
   logic                   accept;
   logic                   taken;

   assign smp          = req_if.sample[SAMPLE_BITS-1:0];
   assign req_if.ready = job_ready;
   assign accept       = req_if.valid && job_ready;
   // a full set ignores further samples but still closes on last
   assign taken        = count_ff < COUNT_BITS'(MAX_SAMPLES);

   always_comb begin
      sum_in   = sum_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      count_in = count_ff;
      if (taken) begin
         if (count_ff == '0) begin
            max_in = smp;
            min_in = smp;
         end else begin
            if (smp > max_ff) max_in = smp;
            if (smp < min_ff) min_in = smp;
         end
         sum_in   = sum_ff + SUM_BITS'(smp);
         count_in = count_ff + 1'b1;
      end
   end

   assign job_valid = accept && req_if.last;
   assign job_data  = {sum_in, max_in, min_in, count_in};

   always_ff @(posedge clock) begin
      if (reset || (accept && req_if.last)) begin
         sum_ff   <= '0;
         max_ff   <= '0;
         min_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         sum_ff   <= sum_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/tmf_fifo.sv
// small flip-flop queue between front and back end
module tmf_fifo import tmf_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FILL_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 push;
   logic                 pop;

   assign push_ready = fill_ff != FILL_BITS'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/tmf_back.sv
// back end: trims, scales by ten and divides by the kept count one bit a cycle
module tmf_back import tmf_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int COUNT_BITS  = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS,
   localparam int JOB_BITS    = SUM_BITS + 2 * SAMPLE_BITS + COUNT_BITS,
   localparam int SCALED_BITS = SUM_BITS + 4,
   localparam int STEP_BITS   = $clog2(SCALED_BITS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  logic [JOB_BITS-1:0] job_data,
   output logic                job_ready,
   tmf_rsp_if.source           rsp_if
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCALE = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [SCALED_BITS-1:0] dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [COUNT_BITS-1:0]  div_ff, div_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   few_ff, few_in;
   logic                   out_valid_ff, out_valid_in;
   mean_type               out_mean_ff, out_mean_in;
   logic                   out_few_ff, out_few_in;

   logic [SUM_BITS-1:0]    job_sum;
   logic [SAMPLE_BITS-1:0] job_max;
   logic [SAMPLE_BITS-1:0] job_min;
   logic [COUNT_BITS-1:0]  job_count;
   logic                   job_few;
   logic [COUNT_BITS:0]    trial;
   logic [COUNT_BITS:0]    diff;
   logic                   ge;

   assign {job_sum, job_max, job_min, job_count} = job_data;
   assign job_few   = job_count <= COUNT_BITS'(TRIM_COUNT);
   assign job_ready = state_ff == S_IDLE;

   // restoring division step, quotient bits shift into the dividend
   assign trial = {rem_ff, dvd_ff[SCALED_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.mean_times_ten = out_mean_ff;
   assign rsp_if.too_few        = out_few_ff;

   always_comb begin
      state_in     = state_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      few_in       = few_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_mean_in  = out_mean_ff;
      out_few_in   = out_few_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               few_in  = job_few;
               div_in  = job_count - COUNT_BITS'(TRIM_COUNT);
               rem_in  = '0;
               step_in = STEP_BITS'(SCALED_BITS - 1);
               if (job_few) begin
                  dvd_in   = '0;
                  state_in = S_DONE;
               end else begin
                  dvd_in   = SCALED_BITS'(job_sum - SUM_BITS'(job_max) - SUM_BITS'(job_min));
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            // times ten as 8x + 2x
            dvd_in   = (dvd_ff << 3) + (dvd_ff << 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            dvd_in = {dvd_ff[SCALED_BITS-2:0], ge};
            if (step_ff == '0) state_in = S_DONE;
            else step_in = step_ff - 1'b1;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in = 1'b1;
               out_mean_in  = MEAN_W'(dvd_ff);
               out_few_in   = few_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      few_ff      <= few_in;
      out_mean_ff <= out_mean_in;
      out_few_ff  <= out_few_in;
   end

endmodule

FILE: rtl/trimmed_mean_filter.sv
// trimmed_mean_filter: drops max and min of a set and gives ten times the mean of the rest
//
// req_if carries one sample per beat; last marks the final sample of a set.
// rsp_if carries one result per set: mean_times_ten and too_few (set of two or
// fewer samples, result 0). Samples beyond MAX_SAMPLES in a set are ignored.
// Only the low SAMPLE_BITS bits of a sample are used.
// Throughput: the front end takes one sample per cycle while the queue is not
// full. The back end works on one set at a time, with a one bit per cycle
// divider, and takes no new set until the last result is in its output
// register; a short set skips the scale and divide steps. A two-entry queue
// sits between them, so req_if.ready drops only when it is full.
// Reset (synchronous) clears the running set, the queue and the output
// register. When the receiver stalls, the result holds in the output
// register, the back end finishes its next set and waits, and the queue fills
// before the input is held off.
module trimmed_mean_filter import tmf_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int COUNT_BITS = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS,
   localparam int JOB_BITS   = SUM_BITS + 2 * SAMPLE_BITS + COUNT_BITS
) (
   input  logic      clock,
   input  logic      reset,
   tmf_req_if.sink   req_if,
   tmf_rsp_if.source rsp_if
);

   logic                push_valid;
   logic [JOB_BITS-1:0] push_data;
   logic                push_ready;
   logic                pop_valid;
   logic [JOB_BITS-1:0] pop_data;
   logic                pop_ready;

   tmf_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .job_valid (push_valid),
      .job_data  (push_data),
      .job_ready (push_ready)
   );

   tmf_fifo #(
      .WIDTH (JOB_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   tmf_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_data  (pop_data),
      .job_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

FILE: rtl/tmf_checker.sv
// port-level checks for the trimmed mean filter and their bind
module tmf_checker import tmf_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input mean_type rsp_mean_times_ten,
   input logic     rsp_too_few
);

   // a result waits until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mean_times_ten) && $stable(rsp_too_few))
      else $error("stalled result changed");

   // a short set must report a zero mean
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_few |-> rsp_mean_times_ten == '0)
      else $error("too_few result with nonzero mean");

   // no result leaves the block right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind trimmed_mean_filter tmf_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_mean_times_ten (rsp_if.mean_times_ten),
   .rsp_too_few        (rsp_if.too_few)
);
